// ===== hw/rtl/ioscl_pkg.sv =====
// Shared types, constants and the window clamp for the channel scale/clamp block.
package ioscl_pkg;

   localparam int QUO_BITS = 32;
   localparam int REG_IDX_W = 2;
   localparam logic [31:0] SAT_MAX_S32 = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_MIN_S32 = 32'h8000_0000;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_SCALE      = 2'd0,
      REG_OFFSET     = 2'd1,
      REG_LIMIT_LOW  = 2'd2,
      REG_LIMIT_HIGH = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic signed [31:0] scale;
      logic signed [47:0] offset;
      logic signed [31:0] limit_low;
      logic signed [31:0] limit_high;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic        func;
      logic        clamped;
      logic        sat;
      logic        ovf;
      logic        neg;
      logic [31:0] value;
      logic [31:0] rem;
      logic [31:0] quo;
   } cell_type;

   typedef struct packed {
      logic        clamped;
      logic [31:0] value;
   } win_type;

   function automatic win_type clamp_window(input logic signed [31:0] v,
                                            input logic signed [31:0] lo,
                                            input logic signed [31:0] hi);
      win_type w;
      w.clamped = 1'b0;
      w.value   = v;
      if (lo <= hi) begin
         if (v < lo) begin
            w.clamped = 1'b1;
            w.value   = lo;
         end else if (v > hi) begin
            w.clamped = 1'b1;
            w.value   = hi;
         end
      end
      return w;
   endfunction

endpackage

// ===== hw/rtl/io_channel_scale_clamp.sv =====
// Throughput: one item per cycle unless held; four front stages, a row of 32 divider cells
// (one quotient bit each) and the output register form one pipeline.
// The whole pipeline holds while a result waits in the output register unaccepted.
// Reset (synchronous): clears the pipeline valids and the violation counter, and
// loads scale 1.0, offset 0, and an inverted (disabled) safety window.
module io_channel_scale_clamp #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value_in
   input  logic        req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] value_out, [63:32] violation_total
   output logic [1:0]  rsp_tuser,   // [0] clamped, [1] saturated
   input  logic        csr_we,
   input  logic [ioscl_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [47:0] csr_wdata
);
   import ioscl_pkg::*;

   localparam logic [31:0] SCALE_ONE = 32'(64'd1 << FRAC_BITS);

   logic signed [31:0] scale_ff;
   logic signed [47:0] offset_ff;
   logic signed [31:0] limit_low_ff;
   logic signed [31:0] limit_high_ff;
   cfg_type            cfg;
   logic [31:0]        dmag;
   logic               en;

   cell_type           chain [0:QUO_BITS];
   cell_type           last;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        value_ff, value_in;
   logic               clamped_ff;
   logic               sat_ff, sat_in;
   logic [31:0]        count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff      <= SCALE_ONE;
         offset_ff     <= '0;
         limit_low_ff  <= 32'sd1;
         limit_high_ff <= 32'sd0;
      end else if (csr_we) begin
         case (csr_index)
            REG_SCALE:      scale_ff      <= csr_wdata[31:0];
            REG_OFFSET:     offset_ff     <= csr_wdata;
            REG_LIMIT_LOW:  limit_low_ff  <= csr_wdata[31:0];
            REG_LIMIT_HIGH: limit_high_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.scale      = scale_ff;
      cfg.offset     = offset_ff;
      cfg.limit_low  = limit_low_ff;
      cfg.limit_high = limit_high_ff;
      dmag           = scale_ff[31] ? 32'(-scale_ff) : scale_ff;
   end

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   ioscl_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .cfg      (cfg),
      .dmag     (dmag),
      .in_valid (req_tvalid),
      .in_func  (req_tuser),
      .in_value (req_tdata),
      .out_ff   (chain[0])
   );

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
      ioscl_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .dmag    (dmag),
         .up_cell (chain[i]),
         .cell_ff (chain[i+1])
      );
   end

   assign last = chain[QUO_BITS];

   // for output-direction items, sign and saturate the quotient; bump the counter in item order
   always_comb begin
      value_in = last.value;
      sat_in   = last.sat;
      if (last.func) begin
         if (scale_ff == 32'sd0) begin
            value_in = last.value;
            sat_in   = 1'b0;
         end else if (last.ovf) begin
            sat_in   = 1'b1;
            value_in = last.neg ? SAT_MIN_S32 : SAT_MAX_S32;
         end else if (last.neg) begin
            sat_in   = last.quo > SAT_MIN_S32;
            value_in = sat_in ? SAT_MIN_S32 : (32'd0 - last.quo);
         end else begin
            sat_in   = last.quo[31];
            value_in = sat_in ? SAT_MAX_S32 : last.quo;
         end
      end
      rsp_valid_in = en ? last.valid : rsp_valid_ff;
      count_in     = count_ff;
      if (en && last.valid) begin
         count_in = count_ff + 32'(last.clamped);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         value_ff   <= value_in;
         clamped_ff <= last.clamped;
         sat_ff     <= sat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {count_ff, value_ff};
   assign rsp_tuser  = {sat_ff, clamped_ff};

endmodule

// ===== hw/rtl/ioscl_front.sv =====
// Front stages: multiply or window and subtract, bias add or magnitude, truncate and saturate or seed, window.
module ioscl_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  ioscl_pkg::cfg_type  cfg,
   input  logic [31:0]         dmag,
   input  logic                in_valid,
   input  logic                in_func,
   input  logic signed [31:0]  in_value,
   output ioscl_pkg::cell_type out_ff
);
   import ioscl_pkg::*;

   localparam int NW = ((31 + FRAC_BITS > 47) ? 31 + FRAC_BITS : 47) + 2;
   localparam logic [63:0] LOW_MASK = (64'd1 << FRAC_BITS) - 64'd1;

   win_type            win_a;
   logic signed [NW-1:0] n_a;
   logic signed [63:0] prod_a;

   logic               a_valid_ff, a_valid_in;
   logic               a_func_ff, a_func_in;
   logic               a_clamped_ff, a_clamped_in;
   logic [31:0]        a_eng_ff, a_eng_in;
   logic signed [63:0] a_acc_ff, a_acc_in;

   logic               b_valid_ff;
   logic               b_func_ff;
   logic               b_clamped_ff;
   logic [31:0]        b_eng_ff;
   logic               b_neg_ff, b_neg_in;
   logic signed [63:0] b_acc_ff, b_acc_in;

   logic signed [63:0] q_c;
   logic               q_sat_c;
   cell_type           c_ff, c_in;

   win_type            win_d;
   cell_type           out_in;

   // raw times gain, or window then scaled engineering value less bias
   always_comb begin
      win_a        = clamp_window(in_value, cfg.limit_low, cfg.limit_high);
      prod_a       = in_value * cfg.scale;
      n_a          = (NW'(signed'(win_a.value)) <<< FRAC_BITS) - NW'(cfg.offset);
      a_valid_in   = in_valid;
      a_func_in    = in_func;
      a_clamped_in = in_func & win_a.clamped;
      a_eng_in     = win_a.value;
      a_acc_in     = in_func ? 64'(n_a) : prod_a;
   end

   // add bias, or take magnitude and quotient sign
   always_comb begin
      b_neg_in = a_acc_ff[63] ^ cfg.scale[31];
      if (a_func_ff) begin
         b_acc_in = a_acc_ff[63] ? -a_acc_ff : a_acc_ff;
      end else begin
         b_acc_in = a_acc_ff + 64'(cfg.offset);
      end
   end

   // truncate toward zero and saturate, or seed the divider
   always_comb begin
      q_c     = (b_acc_ff >>> FRAC_BITS)
              + signed'(64'(b_acc_ff[63] && ((b_acc_ff & LOW_MASK) != 64'd0)));
      q_sat_c = !((&q_c[63:31]) || !(|q_c[63:31]));
      c_in.valid   = b_valid_ff;
      c_in.func    = b_func_ff;
      c_in.clamped = b_clamped_ff;
      c_in.neg     = b_neg_ff;
      if (b_func_ff) begin
         c_in.value = b_eng_ff;
         c_in.sat   = 1'b0;
         c_in.ovf   = b_acc_ff[63:32] >= dmag;
         c_in.rem   = b_acc_ff[63:32];
         c_in.quo   = b_acc_ff[31:0];
      end else begin
         c_in.value = q_sat_c ? (q_c[63] ? SAT_MIN_S32 : SAT_MAX_S32) : q_c[31:0];
         c_in.sat   = q_sat_c;
         c_in.ovf   = 1'b0;
         c_in.rem   = '0;
         c_in.quo   = '0;
      end
   end

   // window the engineering result of input-direction items
   always_comb begin
      win_d  = clamp_window(signed'(c_ff.value), cfg.limit_low, cfg.limit_high);
      out_in = c_ff;
      if (!c_ff.func) begin
         out_in.value   = win_d.value;
         out_in.clamped = win_d.clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_ff.valid   <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (en) begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
         c_ff       <= c_in;
         out_ff     <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_func_ff    <= a_func_in;
         a_clamped_ff <= a_clamped_in;
         a_eng_ff     <= a_eng_in;
         a_acc_ff     <= a_acc_in;
         b_func_ff    <= a_func_ff;
         b_clamped_ff <= a_clamped_ff;
         b_eng_ff     <= a_eng_ff;
         b_neg_ff     <= b_neg_in;
         b_acc_ff     <= b_acc_in;
      end
   end

endmodule

// ===== hw/rtl/ioscl_div_cell.sv =====
// One restoring-division cell: develops one quotient bit and hands the item on.
module ioscl_div_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic [31:0]         dmag,
   input  ioscl_pkg::cell_type up_cell,
   output ioscl_pkg::cell_type cell_ff
);
   import ioscl_pkg::*;

   logic [32:0] trial;
   logic        ge;
   cell_type    cell_in;

   always_comb begin
      trial        = {up_cell.rem, up_cell.quo[31]};
      ge           = trial >= {1'b0, dmag};
      cell_in      = up_cell;
      cell_in.rem  = ge ? 32'(trial - {1'b0, dmag}) : trial[31:0];
      cell_in.quo  = {up_cell.quo[30:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

endmodule

// ===== hw/rtl/ioscl_checker.sv =====
// Port-level checks for the channel scale/clamp block, bound to its top level.
module ioscl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   logic [31:0] last_total_ff, last_total_in;

   assign last_total_in = (rsp_tvalid && rsp_tready) ? rsp_tdata[63:32] : last_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_total_ff <= '0;
      end else begin
         last_total_ff <= last_total_in;
      end
   end

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |->
         rsp_tdata[63:32] == last_total_ff + 32'(rsp_tuser[0]))
      else $error("violation total does not follow clamp flag");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result item changed");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while pipeline is held");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input refused with empty output register");

endmodule

bind io_channel_scale_clamp ioscl_checker u_ioscl_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the I/O channel scale and clamp block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ioscl_pkg::*;

   localparam int FRAC = 16;
   localparam logic FUNC_TO_ENG = 1'b0;
   localparam logic FUNC_TO_RAW = 1'b1;
   localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] S32_MIN = 32'h8000_0000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS = 55;

   typedef struct packed {
      logic [31:0] value_out;
      logic        clamped;
      logic        saturated;
      logic [31:0] violation_total;
   } conv_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // [31:0] value_in
   logic        req_tuser = 1'b0;  // [0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [31:0] value_out, [63:32] violation_total
   logic [1:0]  rsp_tuser;         // [0] clamped, [1] saturated
   logic        csr_we = 1'b0;
   logic [REG_IDX_W-1:0] csr_index = '0;
   logic [47:0] csr_wdata = '0;

   logic signed [31:0] cfg_scale = 32'sd65536;
   logic signed [47:0] cfg_offset = '0;
   logic signed [31:0] cfg_low = 32'sd1;
   logic signed [31:0] cfg_high = 32'sd0;
   logic [31:0] violation_tally = '0;

   conv_result_type expected_q[$];
   int n_errors = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_clamps = 0;
   int n_sats = 0;
   int n_writes = 0;
   int burst_left = 0;
   int gap_level = 0;
   int stall_level = 0;
   int hold_cnt = 0;

   io_channel_scale_clamp #(.FRAC_BITS(FRAC)) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [31:0] sat_to_s32(input longint x, output logic sat);
      sat = 1'b0;
      if (x > longint'($signed(S32_MAX))) begin
         sat = 1'b1;
         return S32_MAX;
      end
      if (x < longint'($signed(S32_MIN))) begin
         sat = 1'b1;
         return S32_MIN;
      end
      return x[31:0];
   endfunction

   function automatic logic [31:0] apply_window(input logic signed [31:0] v,
                                                output logic hit);
      hit = 1'b0;
      if (cfg_low > cfg_high) return v;
      if (v < cfg_low || v > cfg_high) begin
         hit = 1'b1;
         violation_tally = violation_tally + 32'd1;
         return (v < cfg_low) ? cfg_low : cfg_high;
      end
      return v;
   endfunction

   function automatic conv_result_type convert_channel(input logic fn,
                                                       input logic signed [31:0] v);
      conv_result_type r;
      longint sc;
      longint off;
      longint s;
      longint q;
      longint n;
      logic signed [31:0] eng;
      logic sat;
      logic hit;
      r = '0;
      sat = 1'b0;
      sc = cfg_scale;
      off = cfg_offset;
      if (fn == FUNC_TO_ENG) begin
         s = longint'(v) * sc + off;
         q = (s < 0) ? -((-s) >>> FRAC) : (s >>> FRAC);
         eng = sat_to_s32(q, sat);
         r.value_out = apply_window(eng, hit);
      end else begin
         eng = apply_window(v, hit);
         if (sc == 0) begin
            r.value_out = eng;
         end else begin
            n = (longint'(eng) <<< FRAC) - off;
            r.value_out = sat_to_s32(n / sc, sat);
         end
      end
      r.clamped = hit;
      r.saturated = sat;
      r.violation_total = violation_tally;
      return r;
   endfunction

   task automatic send_item(input logic fn, input logic [31:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (gap_level != 0) begin
            gap = $urandom_range(0, 3 * gap_level);
            if (gap != 0) begin
               req_tvalid = 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tdata = value;
      req_tuser = fn;
      do @(posedge clock); while (!req_tready);
      expected_q.push_back(convert_channel(fn, value));
      n_sent++;
      @(negedge clock);
   endtask

   task automatic write_csr(input reg_idx_type idx, input logic [47:0] data);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (expected_q.size() != 0) @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         REG_SCALE:      cfg_scale = data[31:0];
         REG_OFFSET:     cfg_offset = data;
         REG_LIMIT_LOW:  cfg_low = data[31:0];
         REG_LIMIT_HIGH: cfg_high = data[31:0];
         default: ;
      endcase
      n_writes++;
   endtask

   // receiver: always ready at level 0, else alternating ready runs and stalls
   always @(negedge clock) begin
      if (stall_level == 0) begin
         rsp_tready = 1'b1;
      end else if (hold_cnt > 0) begin
         hold_cnt--;
      end else begin
         hold_cnt = rsp_tready ? $urandom_range(0, 3 * stall_level) : $urandom_range(0, 12);
         rsp_tready = !rsp_tready;
      end
   end

   always @(posedge clock) begin
      conv_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result value_out=%h", rsp_tdata[31:0]);
            n_errors++;
         end else begin
            want = expected_q.pop_front();
            n_checked++;
            if (want.clamped) n_clamps++;
            if (want.saturated) n_sats++;
            if (rsp_tdata[31:0] !== want.value_out) begin
               $error("value_out: expected %h, got %h", want.value_out, rsp_tdata[31:0]);
               n_errors++;
            end
            if (rsp_tuser[0] !== want.clamped) begin
               $error("clamped: expected %b, got %b", want.clamped, rsp_tuser[0]);
               n_errors++;
            end
            if (rsp_tuser[1] !== want.saturated) begin
               $error("saturated: expected %b, got %b", want.saturated, rsp_tuser[1]);
               n_errors++;
            end
            if (rsp_tdata[63:32] !== want.violation_total) begin
               $error("violation_total: expected %h, got %h",
                      want.violation_total, rsp_tdata[63:32]);
               n_errors++;
            end
         end
      end
   end

   task automatic test_reset_defaults();
      send_item(FUNC_TO_ENG, 32'd0);
      send_item(FUNC_TO_ENG, S32_MAX);
      send_item(FUNC_TO_ENG, S32_MIN);
      send_item(FUNC_TO_RAW, 32'hFFFF_FFFF);
      send_item(FUNC_TO_RAW, S32_MAX);
   endtask

   task automatic test_input_conversion();
      write_csr(REG_SCALE, {16'hA5A5, S32_MAX});
      write_csr(REG_OFFSET, 48'h7FFF_FFFF_FFFF);
      send_item(FUNC_TO_ENG, S32_MAX);
      write_csr(REG_SCALE, {16'h0000, S32_MIN});
      send_item(FUNC_TO_ENG, S32_MAX);
      write_csr(REG_SCALE, 48'h8000);
      write_csr(REG_OFFSET, 48'd0);
      send_item(FUNC_TO_ENG, -32'sd3);
      send_item(FUNC_TO_ENG, 32'sd3);
      write_csr(REG_SCALE, 48'd0);
      write_csr(REG_OFFSET, 48'h8000_0000_0000);
      send_item(FUNC_TO_ENG, 32'h1234_5678);
      send_item(FUNC_TO_ENG, 32'hFFFF_FFFF);
   endtask

   task automatic test_safety_window();
      write_csr(REG_SCALE, 48'd65536);
      write_csr(REG_OFFSET, 48'd0);
      write_csr(REG_LIMIT_LOW, {16'hFFFF, -32'sd100});
      write_csr(REG_LIMIT_HIGH, 48'd100);
      send_item(FUNC_TO_ENG, 32'sd200);
      send_item(FUNC_TO_ENG, -32'sd200);
      send_item(FUNC_TO_ENG, 32'sd100);
      send_item(FUNC_TO_RAW, -32'sd200);
      send_item(FUNC_TO_RAW, 32'sd101);
      write_csr(REG_LIMIT_LOW, 48'd7);
      write_csr(REG_LIMIT_HIGH, 48'd7);
      send_item(FUNC_TO_ENG, 32'sd7);
      send_item(FUNC_TO_ENG, 32'sd8);
   endtask

   task automatic test_zero_scale();
      write_csr(REG_LIMIT_LOW, 48'd1);
      write_csr(REG_LIMIT_HIGH, 48'd0);
      write_csr(REG_SCALE, 48'd0);
      write_csr(REG_OFFSET, 48'd12345 << 16);
      send_item(FUNC_TO_RAW, S32_MIN);
      send_item(FUNC_TO_RAW, S32_MAX);
   endtask

   task automatic test_output_conversion();
      write_csr(REG_OFFSET, 48'd0);
      write_csr(REG_SCALE, 48'd1);
      send_item(FUNC_TO_RAW, S32_MAX);
      send_item(FUNC_TO_RAW, S32_MIN);
      write_csr(REG_SCALE, {16'h0000, 32'hFFFF_FFFF});
      send_item(FUNC_TO_RAW, 32'sd5);
      write_csr(REG_SCALE, {16'h0000, S32_MIN});
      write_csr(REG_OFFSET, 48'h7FFF_FFFF_FFFF);
      send_item(FUNC_TO_RAW, S32_MIN);
   endtask

   task automatic test_random_settings();
      logic [31:0] sc;
      logic [47:0] off;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      logic [63:0] wide;
      logic [31:0] v;
      longint tmp;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 5))
            0: sc = 32'd65536;
            1: sc = 32'd0;
            2: sc = S32_MAX;
            3: sc = S32_MIN;
            4: sc = $urandom;
            default: sc = 32'($signed($urandom_range(0, 32'h60000)) - 32'sh30000);
         endcase
         wide = {$urandom, $urandom};
         case ($urandom_range(0, 4))
            0: off = 48'd0;
            1: off = wide[47:0];
            2: off = ($urandom_range(0, 1) != 0) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
            default: begin
               tmp = longint'($urandom_range(0, 1 << 26)) - (1 << 25);
               off = tmp[47:0];
            end
         endcase
         a = $urandom;
         b = $urandom;
         case ($urandom_range(0, 3))
            0: begin
               lo = (a > b) ? a : b;
               hi = (a > b) ? b : a;
               if (lo == hi) hi = lo - 1;
            end
            1: begin
               lo = (a > b) ? b : a;
               hi = (a > b) ? a : b;
            end
            2: begin
               lo = -$signed($urandom_range(0, 5000));
               hi = $urandom_range(0, 5000);
            end
            default: begin
               lo = $signed($urandom_range(0, 2000)) - 1000;
               hi = lo + $urandom_range(0, 3);
            end
         endcase
         write_csr(REG_SCALE, {16'($urandom), sc});
         write_csr(REG_OFFSET, off);
         write_csr(REG_LIMIT_LOW, {16'($urandom), lo});
         write_csr(REG_LIMIT_HIGH, {16'($urandom), hi});
         gap_level = $urandom_range(0, 3);
         stall_level = $urandom_range(0, 3);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            case ($urandom_range(0, 7))
               0, 1: v = $urandom;
               2: v = 32'($signed($urandom_range(0, 2000)) - 1000);
               3: v = ($urandom_range(0, 1) != 0) ? S32_MAX : S32_MIN;
               4: v = cfg_low + $urandom_range(0, 4) - 2;
               5: v = cfg_high + $urandom_range(0, 4) - 2;
               default: v = 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            endcase
            send_item(1'($urandom_range(0, 1)), v);
         end
      end
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      stall_level = 2;
      gap_level = 1;
      test_input_conversion();
      test_safety_window();
      stall_level = 0;
      gap_level = 0;
      test_zero_scale();
      stall_level = 3;
      test_output_conversion();
      test_random_settings();
      req_tvalid = 1'b0;
      stall_level = 1;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Covered %0d items over %0d register writes: %0d results checked,",
               n_sent, n_writes, n_checked);
      $display("%0d of them clamped by the window and %0d saturated.", n_clamps, n_sats);
      if (n_errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", expected_q.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/ioscl_pkg.sv
hw/rtl/ioscl_front.sv
hw/rtl/ioscl_div_cell.sv
hw/rtl/io_channel_scale_clamp.sv
hw/rtl/ioscl_checker.sv
tb/tb.sv
